/* hw/rtl/mexp_pkg.sv */
`timescale 1ns / 1ps
// Package for the modular exponentiation block: widths, register indexes, reset values
// and the sequencer state type. No dependencies.
package mexp_pkg;

	localparam int MOD_WIDTH_DEF = 16;
	localparam int EXP_WIDTH_DEF = 32;
	localparam int BASE_WIDTH    = 32;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd1;

	localparam int MODULUS_RST  = 221;
	localparam int EXPONENT_RST = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_BIT,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} mexp_state_t;

endpackage

/* hw/rtl/mexp_base_if.sv */
`timescale 1ns / 1ps
// Input channel of the modular exponentiation block: one base value per beat.
// Depends on mexp_pkg.
interface mexp_base_if
	import mexp_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [BASE_WIDTH-1:0] base_value;

	modport source (output valid, output base_value, input ready);
	modport sink (input valid, input base_value, output ready);
endinterface

/* hw/rtl/mexp_power_if.sv */
`timescale 1ns / 1ps
// Output channel of the modular exponentiation block: one reduced power per beat.
// Depends on mexp_pkg for the default width.
interface mexp_power_if
	import mexp_pkg::*;
#(
	parameter int MOD_WIDTH = MOD_WIDTH_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [MOD_WIDTH-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

/* hw/rtl/mexp_cfg_if.sv */
`timescale 1ns / 1ps
// Register write channel of the modular exponentiation block: index and data per beat.
// Depends on mexp_pkg.
interface mexp_cfg_if
	import mexp_pkg::*;
#(
	parameter int DATA_W = EXP_WIDTH_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/modular_exponentiation.sv */
`timescale 1ns / 1ps
// Modular exponentiation top level: right-to-left square-and-multiply on one shared
// shift-add modular step unit. Depends on mexp_pkg and the three channel interfaces.
//
//   channel  role   payload                      width
//   base     sink   base_value                   32
//   power    source power_result                 MOD_WIDTH
//   cfg      sink   index / data (modulus, exp)  1 / max(MOD_WIDTH, EXP_WIDTH)
//
// Each item is reduced modulo the modulus bit by bit, then each exponent bit gets a
// select state, a multiply if set and a squaring; the result then goes out on power.
// The single step unit does one bit of a modular reduction or product per cycle.
// Reset loads modulus 221 and exponent 5. base.ready is high only while idle; the
// result holds on power until taken. cfg is always ready.
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int MOD_WIDTH = MOD_WIDTH_DEF,
	parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mexp_base_if.sink   base,
	mexp_power_if.source power,
	mexp_cfg_if.sink    cfg
);

	localparam int LEN_MX = (MOD_WIDTH > BASE_WIDTH) ? MOD_WIDTH : BASE_WIDTH;
	localparam int CNT_W  = $clog2(LEN_MX);
	localparam int BIDX_W = $clog2(EXP_WIDTH + 1);
	localparam int W1     = MOD_WIDTH + 1;

	mexp_state_t state_q, state_d;

	logic [MOD_WIDTH-1:0]  mod_q;
	logic [EXP_WIDTH-1:0]  exp_q;
	logic [MOD_WIDTH-1:0]  m_q;
	logic [EXP_WIDTH-1:0]  e_q;
	logic [BASE_WIDTH-1:0] b_q;
	logic [MOD_WIDTH-1:0]  r_q;
	logic [MOD_WIDTH-1:0]  mplier_q;
	logic [MOD_WIDTH-1:0]  pw_q;
	logic [MOD_WIDTH-1:0]  acc_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [BIDX_W-1:0]     bidx_q;

	logic                  base_acc;
	logic                  power_acc;
	logic                  step_bit;
	logic [MOD_WIDTH-1:0]  step_add;
	logic [W1-1:0]         dbl;
	logic [W1-1:0]         t1;
	logic [W1-1:0]         sum;
	logic [MOD_WIDTH-1:0]  step_r;
	logic                  red_end;
	logic                  mul_end;
	logic                  exp_end;

	assign base_acc  = base.valid && base.ready;
	assign power_acc = power.valid && power.ready;
	assign red_end   = (cnt_q == CNT_W'(BASE_WIDTH - 1));
	assign mul_end   = (cnt_q == CNT_W'(MOD_WIDTH - 1));
	assign exp_end   = (bidx_q == BIDX_W'(EXP_WIDTH - 1));

	// Shared step: r <- (2r + bit * add) mod m, with r below m and add at most m.
	always_comb begin
		if (state_q == ST_REDUCE) begin
			step_bit = b_q[BASE_WIDTH-1];
			step_add = MOD_WIDTH'(1);
		end else begin
			step_bit = mplier_q[MOD_WIDTH-1];
			step_add = pw_q;
		end
		dbl = {r_q, 1'b0};
		t1  = (dbl >= {1'b0, m_q}) ? (dbl - {1'b0, m_q}) : dbl;
		sum = t1 + (step_bit ? {1'b0, step_add} : '0);
		if (sum >= {1'b0, m_q}) begin
			step_r = MOD_WIDTH'(sum - {1'b0, m_q});
		end else begin
			step_r = MOD_WIDTH'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_WIDTH'(MODULUS_RST);
			exp_q <= EXP_WIDTH'(EXPONENT_RST);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MODULUS:  mod_q <= cfg.data[MOD_WIDTH-1:0];
				REG_EXPONENT: exp_q <= cfg.data[EXP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (base_acc) state_d = ST_REDUCE;
			ST_REDUCE: if (red_end) state_d = ST_BIT;
			ST_BIT:    state_d = e_q[0] ? ST_MUL : ST_SQR;
			ST_MUL:    if (mul_end) state_d = ST_SQR;
			ST_SQR: begin
				if (mul_end) state_d = exp_end ? ST_DONE : ST_BIT;
			end
			ST_DONE:   if (power_acc) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		base.ready         = (state_q == ST_IDLE);
		power.valid        = (state_q == ST_DONE);
		power.power_result = acc_q;
		cfg.ready          = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (base_acc) begin
					b_q    <= base.base_value;
					m_q    <= (mod_q == '0) ? MOD_WIDTH'(1) : mod_q;
					e_q    <= exp_q;
					r_q    <= '0;
					cnt_q  <= '0;
					bidx_q <= '0;
				end
			end
			ST_REDUCE: begin
				r_q   <= step_r;
				b_q   <= {b_q[BASE_WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
				if (red_end) begin
					pw_q  <= step_r;
					acc_q <= MOD_WIDTH'(1);
				end
			end
			ST_BIT: begin
				r_q      <= '0;
				cnt_q    <= '0;
				mplier_q <= e_q[0] ? acc_q : pw_q;
			end
			ST_MUL: begin
				if (mul_end) begin
					acc_q    <= step_r;
					r_q      <= '0;
					cnt_q    <= '0;
					mplier_q <= pw_q;
				end else begin
					r_q      <= step_r;
					mplier_q <= {mplier_q[MOD_WIDTH-2:0], 1'b0};
					cnt_q    <= cnt_q + CNT_W'(1);
				end
			end
			ST_SQR: begin
				r_q      <= step_r;
				mplier_q <= {mplier_q[MOD_WIDTH-2:0], 1'b0};
				cnt_q    <= cnt_q + CNT_W'(1);
				if (mul_end) begin
					pw_q   <= step_r;
					e_q    <= e_q >> 1;
					bidx_q <= bidx_q + BIDX_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench for modular_exponentiation: loads modulus/exponent keys, streams base values and
// checks every power_result against an in-bench square-and-multiply predictor.
// Depends on mexp_pkg, the base/power/cfg channel interfaces and the modular_exponentiation RTL.
module tb
	import mexp_pkg::*;
();

	logic clk = 1'b0;
	logic arst_n;

	mexp_base_if                          base_ch();
	mexp_power_if #(.MOD_WIDTH(MOD_WIDTH_DEF)) power_ch();
	mexp_cfg_if   #(.DATA_W(EXP_WIDTH_DEF))    cfg_ch();

	modular_exponentiation u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.base   (base_ch),
		.power  (power_ch),
		.cfg    (cfg_ch)
	);

	always #1 clk = ~clk;

	logic [MOD_WIDTH_DEF-1:0] key_modulus  = MOD_WIDTH_DEF'(MODULUS_RST);
	logic [EXP_WIDTH_DEF-1:0] key_exponent = EXP_WIDTH_DEF'(EXPONENT_RST);
	logic [MOD_WIDTH_DEF-1:0] expected_powers[$];
	logic [MOD_WIDTH_DEF-1:0] want_power;
	int unsigned              mismatch_cnt   = 0;
	int unsigned              powers_checked = 0;
	int unsigned              keys_loaded    = 0;
	bit                       source_calm    = 1'b0;
	bit                       sink_calm      = 1'b0;

	function automatic logic [MOD_WIDTH_DEF-1:0] power_mod(input logic [BASE_WIDTH-1:0] b);
		longint unsigned m;
		longint unsigned acc;
		longint unsigned sq;
		m = (key_modulus == '0) ? 64'd1 : 64'(key_modulus);
		sq = 64'(b) % m;
		acc = 64'd1;
		for (int i = 0; i < EXP_WIDTH_DEF; i++) begin
			if (key_exponent[i])
				acc = (acc * sq) % m;
			sq = (sq * sq) % m;
		end
		return acc[MOD_WIDTH_DEF-1:0];
	endfunction

	// Result side: stall a drawn number of cycles once a result shows, then take it.
	always begin : power_sink
		int unsigned stall;
		stall = sink_calm ? 0 : $urandom_range(0, 5);
		if (stall == 0) begin
			power_ch.ready <= 1'b1;
		end else begin
			power_ch.ready <= 1'b0;
			do @(posedge clk); while (!power_ch.valid);
			repeat (stall - 1) @(posedge clk);
			power_ch.ready <= 1'b1;
		end
		do @(posedge clk); while (!(power_ch.valid && power_ch.ready));
	end

	always @(posedge clk) begin
		if (arst_n && power_ch.valid && power_ch.ready) begin
			if (expected_powers.size() == 0) begin
				$error("power_result: expected none, actual %0d", power_ch.power_result);
				mismatch_cnt++;
			end else begin
				want_power = expected_powers.pop_front();
				powers_checked++;
				if (power_ch.power_result !== want_power) begin
					$error("power_result: expected %0d, actual %0d", want_power,
						power_ch.power_result);
					mismatch_cnt++;
				end
			end
		end
	end

	task automatic send_base(input logic [BASE_WIDTH-1:0] b);
		int unsigned gap;
		gap = source_calm ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			base_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		base_ch.valid      <= 1'b1;
		base_ch.base_value <= b;
		do @(posedge clk); while (!base_ch.ready);
		expected_powers.push_back(power_mod(b));
	endtask

	// Drop the base channel and hold until every expected power has come back.
	task automatic wait_powers_out();
		base_ch.valid <= 1'b0;
		while (expected_powers.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_key(input logic [EXP_WIDTH_DEF-1:0] mod_word,
		input logic [EXP_WIDTH_DEF-1:0] exp_word);
		wait_powers_out();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_MODULUS;
		cfg_ch.data  <= mod_word;
		do @(posedge clk); while (!cfg_ch.ready);
		key_modulus = mod_word[MOD_WIDTH_DEF-1:0];
		cfg_ch.index <= REG_EXPONENT;
		cfg_ch.data  <= exp_word;
		do @(posedge clk); while (!cfg_ch.ready);
		key_exponent = exp_word;
		cfg_ch.valid <= 1'b0;
		keys_loaded++;
	endtask

	task automatic test_reset_key();
		send_base('0);
		send_base(32'd1);
		send_base(32'd220);
		send_base(32'd221);
		send_base('1);
	endtask

	task automatic test_exponent_zero();
		set_key(32'd1, 32'd0);
		send_base('0);
		set_key(32'd65535, 32'd0);
		send_base('1);
		send_base(32'd0);
	endtask

	task automatic test_modulus_one();
		set_key(32'd1, '1);
		send_base('1);
		send_base($urandom);
	endtask

	task automatic test_modulus_zero();
		set_key(32'd0, 32'd7);
		send_base(32'd12345);
		set_key(32'h0001_0000, 32'd0);
		send_base('1);
	endtask

	task automatic test_extremes();
		set_key('1, '1);
		send_base('1);
		send_base(32'd65534);
		send_base(32'd2);
		set_key(32'd65521, 32'd65519);
		send_base(32'd3);
		send_base(32'hDEAD_BEEF);
		set_key(32'd2, 32'd1);
		send_base(32'h8000_0001);
		send_base(32'h7FFF_FFFE);
	endtask

	task automatic test_random_keys();
		logic [EXP_WIDTH_DEF-1:0] mod_word;
		logic [EXP_WIDTH_DEF-1:0] exp_word;
		logic [BASE_WIDTH-1:0]    b;
		for (int phase = 0; phase < 20; phase++) begin
			case ($urandom_range(0, 3))
				0: mod_word = $urandom_range(32768, 65535);
				1: mod_word = $urandom_range(1, 255);
				2: mod_word = $urandom_range(1, 65535);
				default: mod_word = {16'($urandom), 16'($urandom_range(1, 65535))};
			endcase
			case ($urandom_range(0, 4))
				0: exp_word = $urandom_range(0, 15);
				1: exp_word = 32'd1 << $urandom_range(0, 31);
				2: exp_word = '1;
				default: exp_word = $urandom;
			endcase
			set_key(mod_word, exp_word);
			source_calm = ($urandom_range(0, 3) == 0);
			sink_calm   = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 26; k++) begin
				case ($urandom_range(0, 7))
					0: b = '0;
					1: b = '1;
					2: b = 32'(key_modulus) * $urandom_range(0, 65535);
					default: b = $urandom;
				endcase
				send_base(b);
			end
		end
		source_calm = 1'b0;
		sink_calm   = 1'b0;
	endtask

	initial begin
		arst_n             <= 1'b0;
		base_ch.valid      <= 1'b0;
		base_ch.base_value <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= REG_MODULUS;
		cfg_ch.data        <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_exponent_zero();
		test_modulus_one();
		test_modulus_zero();
		test_extremes();
		test_random_keys();

		wait_powers_out();
		repeat (1200) @(posedge clk);
		$display("Checked %0d powers across %0d key loads plus the reset key; %0d mismatches.",
			powers_checked, keys_loaded, mismatch_cnt);
		if (mismatch_cnt == 0 && expected_powers.size() == 0) begin
			$display("[modular_exponentiation] OK");
		end else begin
			$display("[modular_exponentiation] ERROR");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("Timed out with %0d powers outstanding.", expected_powers.size());
		$display("[modular_exponentiation] ERROR");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_base_if.sv
hw/rtl/mexp_power_if.sv
hw/rtl/mexp_cfg_if.sv
hw/rtl/modular_exponentiation.sv
dv/tb.sv
